FILE: src/tpte_pkg.sv
package tpte_pkg;

   // Fixed geometry of the two-level walk.
   localparam int VA_W           = 32;
   localparam int DIR_AW         = 10;
   localparam int TBL_IDX_W      = 10;
   localparam int OFF_W          = 12;
   localparam int FRAME_W        = 20;
   localparam int DIR_ENTRIES_C  = 1024;
   localparam int PAGE_ENTRIES_C = 1024;

   localparam logic [VA_W-1:0] KERNEL_BASE = 32'hC000_0000;

   // Operation codes.
   localparam logic [1:0] MODE_TRANSLATE = 2'd0;
   localparam logic [1:0] MODE_MAP       = 2'd1;
   localparam logic [1:0] MODE_UNMAP     = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_DIR_MISSING = 2'd1;
   localparam logic [1:0] STAT_NOT_PRESENT = 2'd2;
   localparam logic [1:0] STAT_NO_SLOT     = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [VA_W-1:0]    vaddr;
      logic [FRAME_W-1:0] frame;
      logic               release_frame;
   } item_type;

   // What the directory stage hands to the page stage.
   typedef struct packed {
      item_type   item;
      logic [1:0] status;
      logic       walk;
   } walk_type;

endpackage

FILE: src/tpte_dir_stage.sv
module tpte_dir_stage
   import tpte_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          paging_on,
   input  logic                          clear_active,
   input  logic [DIR_AW-1:0]             clear_addr,
   input  logic                          in_valid,
   input  item_type                      in_item,
   output logic                          s1_ready,
   output logic                          out_valid,
   input  logic                          out_ready,
   output walk_type                      out_walk,
   output logic [$clog2(TABLE_SLOTS*PAGE_ENTRIES_C)-1:0] out_page_addr
);

   localparam int PAGE_AW = $clog2(TABLE_SLOTS * PAGE_ENTRIES_C);
   localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NS_W    = $clog2(TABLE_SLOTS + 1);

   logic              dir_valid_mem [DIR_ENTRIES_C];
   logic [SLOT_W-1:0] dir_slot_mem  [DIR_ENTRIES_C];

   logic              s1_valid_ff;
   item_type          s1_item_ff;
   logic              rd_valid_ff;
   logic [SLOT_W-1:0] rd_slot_ff;
   logic              fwd_ff;
   logic [SLOT_W-1:0] fwd_slot_ff;
   logic [NS_W-1:0]   next_slot_ff;
   logic [NS_W-1:0]   next_slot_in;

   logic [DIR_AW-1:0] in_di;
   logic [DIR_AW-1:0] s1_di;
   logic              ent_valid;
   logic [SLOT_W-1:0] ent_slot;
   logic              slot_free;
   logic [1:0]        status;
   logic              walk;
   logic              alloc;
   logic [SLOT_W-1:0] slot;
   logic              s1_move;
   logic              alloc_fire;

   assign in_di = in_item.vaddr[VA_W-1 -: DIR_AW];
   assign s1_di = s1_item_ff.vaddr[VA_W-1 -: DIR_AW];

   // An allocation retired in the cycle of the read is taken over directly.
   assign ent_valid = fwd_ff | rd_valid_ff;
   assign ent_slot  = fwd_ff ? fwd_slot_ff : rd_slot_ff;
   assign slot_free = (next_slot_ff != NS_W'(TABLE_SLOTS));

   always_comb begin
      status = STAT_OK;
      walk   = 1'b0;
      alloc  = 1'b0;
      slot   = ent_slot;
      case (s1_item_ff.mode)
         MODE_TRANSLATE: begin
            if (paging_on) begin
               if (ent_valid) begin
                  walk = 1'b1;
               end else begin
                  status = STAT_DIR_MISSING;
               end
            end
         end
         MODE_MAP: begin
            if (ent_valid) begin
               walk = 1'b1;
            end else if (slot_free) begin
               alloc = 1'b1;
               walk  = 1'b1;
               slot  = next_slot_ff[SLOT_W-1:0];
            end else begin
               status = STAT_NO_SLOT;
            end
         end
         MODE_UNMAP: begin
            if (ent_valid) begin
               walk = 1'b1;
            end else begin
               status = STAT_DIR_MISSING;
            end
         end
         default: begin
            walk = 1'b0;
         end
      endcase
   end

   assign s1_move      = s1_valid_ff & out_ready;
   assign s1_ready     = ~s1_valid_ff | out_ready;
   assign alloc_fire   = s1_move & alloc;
   assign next_slot_in = next_slot_ff + NS_W'(1);

   always_ff @(posedge clock) begin
      if (clear_active) begin
         dir_valid_mem[clear_addr] <= 1'b0;
      end else if (alloc_fire) begin
         dir_valid_mem[s1_di] <= 1'b1;
         dir_slot_mem[s1_di]  <= slot;
      end
      if (in_valid) begin
         rd_valid_ff <= dir_valid_mem[in_di];
         rd_slot_ff  <= dir_slot_mem[in_di];
         s1_item_ff  <= in_item;
         fwd_slot_ff <= slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         next_slot_ff <= '0;
      end else begin
         if (in_valid) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= alloc_fire & (s1_di == in_di);
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (alloc_fire) begin
            next_slot_ff <= next_slot_in;
         end
      end
   end

   assign out_valid     = s1_valid_ff;
   assign out_walk      = '{item: s1_item_ff, status: status, walk: walk};
   assign out_page_addr = PAGE_AW'({slot, s1_item_ff.vaddr[OFF_W +: TBL_IDX_W]});

`ifndef ASSERT_OFF
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= NS_W'(TABLE_SLOTS))
      else $error("table pool counter ran past the pool size");

   a_slot_count: assert property (@(posedge clock) disable iff (reset)
      alloc_fire |=> next_slot_ff == $past(next_slot_in))
      else $error("table allocation did not advance the pool counter");
`endif

endmodule

FILE: src/tpte_page_stage.sv
module tpte_page_stage
   import tpte_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          paging_on,
   input  logic                          clear_active,
   input  logic [$clog2(TABLE_SLOTS*PAGE_ENTRIES_C)-1:0] clear_addr,
   input  logic                          in_valid,
   input  walk_type                      in_walk,
   input  logic [$clog2(TABLE_SLOTS*PAGE_ENTRIES_C)-1:0] in_page_addr,
   output logic                          in_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [VA_W-1:0]               rsp_phys_addr,
   output logic [FRAME_W-1:0]            rsp_freed_frame,
   output logic                          rsp_frame_freed
);

   localparam int PAGE_DEPTH = TABLE_SLOTS * PAGE_ENTRIES_C;
   localparam int PAGE_AW    = $clog2(PAGE_DEPTH);

   logic               present_mem [PAGE_DEPTH];
   logic [FRAME_W-1:0] frame_mem   [PAGE_DEPTH];

   logic               s2_valid_ff;
   walk_type           s2_walk_ff;
   logic [PAGE_AW-1:0] s2_addr_ff;
   logic               rd_present_ff;
   logic [FRAME_W-1:0] rd_frame_ff;
   logic               fwd_ff;
   logic               fwd_present_ff;
   logic [FRAME_W-1:0] fwd_frame_ff;
   logic               rsp_valid_ff;
   logic [1:0]         status_ff;
   logic [VA_W-1:0]    phys_ff;
   logic [FRAME_W-1:0] freed_ff;
   logic               flag_ff;

   logic               pg_present;
   logic [FRAME_W-1:0] pg_frame;
   logic [1:0]         status;
   logic [VA_W-1:0]    phys;
   logic [FRAME_W-1:0] freed;
   logic               flag;
   logic               wr;
   logic               wr_present;
   logic [FRAME_W-1:0] wr_frame;
   logic               s2_adv;
   logic               in_fire;
   logic               wr_fire;

   assign pg_present = fwd_ff ? fwd_present_ff : rd_present_ff;
   assign pg_frame   = fwd_ff ? fwd_frame_ff : rd_frame_ff;

   always_comb begin
      status     = s2_walk_ff.status;
      phys       = '0;
      freed      = '0;
      flag       = 1'b0;
      wr         = 1'b0;
      wr_present = 1'b0;
      wr_frame   = '0;
      case (s2_walk_ff.item.mode)
         MODE_TRANSLATE: begin
            if (s2_walk_ff.walk) begin
               if (pg_present) begin
                  phys = {pg_frame, s2_walk_ff.item.vaddr[OFF_W-1:0]};
               end else begin
                  status = STAT_NOT_PRESENT;
               end
            end else if (!paging_on) begin
               phys = s2_walk_ff.item.vaddr - KERNEL_BASE;
            end
         end
         MODE_MAP: begin
            // A page already present keeps its frame.
            if (s2_walk_ff.walk && !pg_present) begin
               wr         = 1'b1;
               wr_present = 1'b1;
               wr_frame   = s2_walk_ff.item.frame;
            end
         end
         MODE_UNMAP: begin
            if (s2_walk_ff.walk) begin
               if (pg_present) begin
                  wr = 1'b1;
                  if (s2_walk_ff.item.release_frame) begin
                     freed = pg_frame;
                     flag  = 1'b1;
                  end
               end else begin
                  status = STAT_NOT_PRESENT;
               end
            end
         end
         default: begin
            status = STAT_OK;
         end
      endcase
   end

   assign s2_adv   = s2_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign in_ready = ~s2_valid_ff | s2_adv;
   assign in_fire  = in_valid & in_ready;
   assign wr_fire  = s2_adv & wr;

   always_ff @(posedge clock) begin
      if (clear_active) begin
         present_mem[clear_addr] <= 1'b0;
      end else if (wr_fire) begin
         present_mem[s2_addr_ff] <= wr_present;
         frame_mem[s2_addr_ff]   <= wr_frame;
      end
      if (in_fire && in_walk.walk) begin
         rd_present_ff <= present_mem[in_page_addr];
         rd_frame_ff   <= frame_mem[in_page_addr];
      end
      if (in_fire) begin
         s2_walk_ff     <= in_walk;
         s2_addr_ff     <= in_page_addr;
         fwd_present_ff <= wr_present;
         fwd_frame_ff   <= wr_frame;
      end
      if (s2_adv) begin
         status_ff <= status;
         phys_ff   <= phys;
         freed_ff  <= freed;
         flag_ff   <= flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_fire) begin
            s2_valid_ff <= 1'b1;
            fwd_ff      <= wr_fire & (s2_addr_ff == in_page_addr);
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_phys_addr   = phys_ff;
   assign rsp_freed_frame = freed_ff;
   assign rsp_frame_freed = flag_ff;

`ifndef ASSERT_OFF
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active |-> !s2_valid_ff)
      else $error("page walk in flight during the clearing pass");
`endif

endmodule

FILE: src/two_level_page_table_engine_unit.sv
// Two-level page table engine.
//
// Each request word carries one operation (translate, map or unmap) on a
// 32-bit virtual address; each one produces exactly one response word with a
// status, a physical address and an optional freed frame. Both channels use
// valid and stall: a word moves on a rising edge where valid is high and
// stall is low. The csr channel writes the paging enable bit and is always
// ready; it is meant to be written only while no request is in flight.
//
// A request reads the directory memory into the directory stage and then the
// page memory into the page stage, and its result is held in the response
// register. The two memory stages overlap, so one word per cycle is sustained
// when the response side does not stall; each memory does one read and at
// most one write per cycle, and a write that lands on the entry being read is
// forwarded. When rsp_stall is held, the response register keeps its word,
// the page stage and then the directory stage fill, and req_stall rises.
//
// After reset both memories are swept clear, one entry per cycle, until all
// TABLE_SLOTS*1024 page entries (16384 at the default) are clear; req_stall
// stays high during the sweep while csr writes are still taken.
module two_level_page_table_engine_unit
   import tpte_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [VA_W-1:0]    req_vaddr,
   input  logic [FRAME_W-1:0] req_frame,
   input  logic               req_release_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [VA_W-1:0]    rsp_phys_addr,
   output logic [FRAME_W-1:0] rsp_freed_frame,
   output logic               rsp_frame_freed,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_paging_on
);

   localparam int PAGE_DEPTH = TABLE_SLOTS * PAGE_ENTRIES_C;
   localparam int PAGE_AW    = $clog2(PAGE_DEPTH);

   logic               paging_on_ff;
   logic               clear_active_ff;
   logic [PAGE_AW-1:0] clear_count_ff;
   logic [PAGE_AW-1:0] clear_count_in;
   logic               clear_last;

   logic               s1_ready;
   logic               req_accept;
   item_type           req_item;
   logic               walk_valid;
   logic               walk_ready;
   walk_type           walk;
   logic [PAGE_AW-1:0] walk_page_addr;

   // The paging enable register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_on_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         paging_on_ff <= csr_paging_on;
      end
   end

   // Clearing sweep after reset. The page memory is at least as deep as the
   // directory, so its counter also covers every directory entry.
   assign clear_count_in = clear_count_ff + PAGE_AW'(1);
   assign clear_last     = (clear_count_ff == PAGE_AW'(PAGE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_count_ff  <= '0;
      end else if (clear_active_ff) begin
         clear_count_ff <= clear_count_in;
         if (clear_last) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   assign req_stall  = clear_active_ff | ~s1_ready;
   assign req_accept = req_valid & ~req_stall;
   assign req_item   = '{mode: req_mode, vaddr: req_vaddr, frame: req_frame,
                         release_frame: req_release_frame};

   tpte_dir_stage #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_dir (
      .clock         (clock),
      .reset         (reset),
      .paging_on     (paging_on_ff),
      .clear_active  (clear_active_ff),
      .clear_addr    (clear_count_ff[DIR_AW-1:0]),
      .in_valid      (req_accept),
      .in_item       (req_item),
      .s1_ready      (s1_ready),
      .out_valid     (walk_valid),
      .out_ready     (walk_ready),
      .out_walk      (walk),
      .out_page_addr (walk_page_addr)
   );

   tpte_page_stage #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_page (
      .clock           (clock),
      .reset           (reset),
      .paging_on       (paging_on_ff),
      .clear_active    (clear_active_ff),
      .clear_addr      (clear_count_ff),
      .in_valid        (walk_valid),
      .in_walk         (walk),
      .in_page_addr    (walk_page_addr),
      .in_ready        (walk_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_phys_addr   (rsp_phys_addr),
      .rsp_freed_frame (rsp_freed_frame),
      .rsp_frame_freed (rsp_frame_freed)
   );

`ifndef ASSERT_OFF
   a_quiet_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !rsp_valid)
      else $error("response word produced during the clearing sweep");

   a_sweep_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_active_ff) |-> $past(clear_last))
      else $error("clearing sweep ended before the last entry");
`endif

endmodule
